FILE: rtl/utp_pkg.sv
// constants and codes shared by the uuid text parser and its checker
package utp_pkg;

  // text layout
  localparam int unsigned TextLen   = 36;
  localparam int unsigned PosBeyond = 37;
  localparam int unsigned ByteTotal = 16;

  localparam logic [5:0] POS_DASH_A  = 6'd9;
  localparam logic [5:0] POS_DASH_B  = 6'd14;
  localparam logic [5:0] POS_DASH_C  = 6'd19;
  localparam logic [5:0] POS_DASH_D  = 6'd24;
  localparam logic [5:0] POS_VERSION = 6'd15;
  localparam logic [5:0] POS_MAGIC   = 6'd20;
  localparam logic [5:0] POS_LAST    = 6'(TextLen);
  localparam logic [5:0] POS_OVER    = 6'(PosBeyond);
  localparam logic [4:0] BYTE_FULL   = 5'(ByteTotal);

  // status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PARSE   = 3'd1,
    ST_VERSION = 3'd2,
    ST_MAGIC   = 3'd3,
    ST_SHORT   = 3'd4,
    ST_IGNORED = 3'd5
  } status_e;

endpackage

FILE: rtl/uuid_text_parser.sv
// uuid text parser: checks 8-4-4-4-12 text and decodes hex pairs to bytes
// a result is registered in the output register when its request is accepted
// throughput: one request per cycle; the output register keeps taking requests
//   while its result is taken in the same cycle
// reset: parse state and the output valid clear at once; counting starts at
//   position 1 even without a first-character flag
module uuid_text_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       first_char_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_value_o,
  output logic [3:0] byte_index_o,
  output logic [2:0] status_o,
  output logic [5:0] char_position_o,
  output logic       complete_o
);
  import utp_pkg::*;

  // parse state
  logic [5:0] pos_q, pos_d;
  logic [3:0] high_q, high_d;
  logic       phase_q, phase_d;
  logic [4:0] bcnt_q, bcnt_d;
  logic       err_q, err_d;

  // result register
  logic       out_valid_q;
  logic       bvalid_q, bvalid_d;
  logic [7:0] bvalue_q, bvalue_d;
  logic [3:0] bindex_q, bindex_d;
  status_e    status_q, status_d;
  logic [5:0] cpos_q;
  logic       done_q, done_d;

  logic       accept;
  logic [5:0] pos_base;
  logic [3:0] high_base;
  logic       phase_base;
  logic [4:0] bcnt_base;
  logic       err_base;
  logic [7:0] lc;
  logic       is_hex, ok, is_dash_pos;
  logic [3:0] nib;
  status_e    code;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // per-character check and nibble pairing
  always_comb begin
    // start flag clears state before the character is taken
    pos_base   = first_char_i ? '0 : pos_q;
    high_base  = first_char_i ? '0 : high_q;
    phase_base = first_char_i ? 1'b0 : phase_q;
    bcnt_base  = first_char_i ? '0 : bcnt_q;
    err_base   = first_char_i ? 1'b0 : err_q;

    pos_d   = (pos_base < POS_OVER) ? pos_base + 6'd1 : pos_base;
    high_d  = high_base;
    phase_d = phase_base;
    bcnt_d  = bcnt_base;
    err_d   = err_base;

    bvalid_d = 1'b0;
    bvalue_d = '0;
    bindex_d = '0;
    status_d = ST_OK;
    done_d   = 1'b0;

    // fold uppercase to lowercase
    lc = char_code_i;
    if (char_code_i inside {[8'h41:8'h5a]}) begin
      lc = char_code_i | 8'h20;
    end

    is_hex = 1'b0;
    nib    = '0;
    if (lc inside {[8'h30:8'h39]}) begin
      is_hex = 1'b1;
      nib    = lc[3:0];
    end else if (lc inside {[8'h61:8'h66]}) begin
      is_hex = 1'b1;
      nib    = lc[3:0] + 4'd9;
    end

    is_dash_pos = (pos_d == POS_DASH_A) || (pos_d == POS_DASH_B) ||
                  (pos_d == POS_DASH_C) || (pos_d == POS_DASH_D);

    // allowed characters at the version and magic positions
    if (pos_d == POS_VERSION) begin
      ok   = lc inside {[8'h31:8'h35]};
      code = ST_VERSION;
    end else if (pos_d == POS_MAGIC) begin
      ok   = lc inside {8'h38, 8'h39, 8'h61, 8'h62};
      code = ST_MAGIC;
    end else begin
      ok   = is_hex;
      code = ST_PARSE;
    end

    if (pos_d > POS_LAST || err_base) begin
      status_d = ST_IGNORED;
    end else begin
      if (is_dash_pos) begin
        if (lc != 8'h2d) begin
          status_d = ST_PARSE;
        end
      end else if (!ok) begin
        status_d = code;
      end else if (!phase_base) begin
        high_d  = nib;
        phase_d = 1'b1;
      end else begin
        bvalue_d = {high_base, nib};
        bindex_d = bcnt_base[3:0];
        if (bcnt_base < BYTE_FULL) begin
          bcnt_d = bcnt_base + 5'd1;
        end
        phase_d  = 1'b0;
        bvalid_d = 1'b1;
      end

      // end flag before the last position
      if (status_d == ST_OK && end_of_text_i && pos_d < POS_LAST) begin
        status_d = ST_SHORT;
      end
      if (status_d != ST_OK) begin
        err_d    = 1'b1;
        bvalid_d = 1'b0;
        bvalue_d = '0;
        bindex_d = '0;
      end else if (pos_d == POS_LAST) begin
        done_d = 1'b1;
      end
    end
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      high_q      <= '0;
      phase_q     <= 1'b0;
      bcnt_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q   <= pos_d;
        high_q  <= high_d;
        phase_q <= phase_d;
        bcnt_q  <= bcnt_d;
        err_q   <= err_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bvalid_q <= bvalid_d;
      bvalue_q <= bvalue_d;
      bindex_q <= bindex_d;
      status_q <= status_d;
      cpos_q   <= pos_d;
      done_q   <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_valid_o    = bvalid_q;
  assign byte_value_o    = bvalue_q;
  assign byte_index_o    = bindex_q;
  assign status_o        = status_q;
  assign char_position_o = cpos_q;
  assign complete_o      = done_q;

endmodule

FILE: rtl/utp_checker.sv
// port-level checks for the uuid text parser, bound to its top level
module utp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       byte_valid_o,
  input logic [7:0] byte_value_o,
  input logic [3:0] byte_index_o,
  input logic [2:0] status_o,
  input logic [5:0] char_position_o,
  input logic       complete_o
);
  import utp_pkg::*;

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(byte_valid_o) && $stable(byte_value_o) && $stable(byte_index_o) &&
      $stable(status_o) && $stable(char_position_o) && $stable(complete_o))
    else $error("stalled result changed");

  // a decoded byte only comes with ok status and never at a dash position
  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |->
      status_o == ST_OK && char_position_o != POS_DASH_A &&
      char_position_o != POS_DASH_B && char_position_o != POS_DASH_C &&
      char_position_o != POS_DASH_D)
    else $error("byte decoded with error or at dash");

  // completion only at the last position with ok status
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && complete_o |-> char_position_o == POS_LAST && status_o == ST_OK)
    else $error("completion flagged at wrong position");

  // characters beyond the text are always ignored
  a_beyond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_position_o == POS_OVER |-> status_o == ST_IGNORED)
    else $error("character beyond text not ignored");

  // a short error is never reported at or past the last position
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SHORT |-> char_position_o < POS_LAST && !byte_valid_o)
    else $error("short error at full length");

endmodule

bind uuid_text_parser utp_checker u_utp_checker (.*);
